>>> sv/swbs_pkg.sv
// ----------------------------------------------------------------------------
// swbs_pkg
// Shared widths, register map, sequencer states and interface structs for
// the sliding window byte statistics block.
// ----------------------------------------------------------------------------
package swbs_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 11;
    localparam int DIST_W     = 9;
    localparam int DTXT_W     = 7;
    localparam int POS_W      = 32;
    localparam int PHASE_W    = 24;
    localparam int MODE_W     = 2;
    localparam int RATIO_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int DIVIDEND_W = CNT_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = 8;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [MODE_W-1:0] MODE_DISTINCT_ALL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISTINCT_TEXT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT_TOTAL    = 2'd2;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [CNT_W-1:0]   DEN_ALL      = 11'd256;
    localparam logic [CNT_W-1:0]   DEN_TEXT     = 11'd96;
    localparam logic [CNT_W-1:0]   WINDOW_RST   = 11'd1024;
    localparam logic [PHASE_W-1:0] INTERVAL_RST = 24'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_WR,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_LOAD,
        ST_DIV
    } seq_state_t;

    typedef struct packed {
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [CNT_W-1:0]   wr_data;
        logic               clear;
    } hist_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> sv/swbs_ring.sv
// ----------------------------------------------------------------------------
// swbs_ring
// Byte ring memory, one port, read-before-write with registered read data.
// ----------------------------------------------------------------------------
module swbs_ring
    import swbs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [AW-1:0]     addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/swbs_hist.sv
// ----------------------------------------------------------------------------
// swbs_hist
// 256-entry byte count histogram with per-entry valid bits; an entry that
// is not valid reads as zero, and a clear drops all valid bits at once.
// ----------------------------------------------------------------------------
module swbs_hist
    import swbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  hist_cmd_t        cmd,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]      mem [HIST_DEPTH];
    logic [CNT_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;
    logic [HIST_DEPTH-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                rd_valid_reg <= valid_reg[cmd.rd_addr];
            end
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.wr_en) begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/swbs_div.sv
// ----------------------------------------------------------------------------
// swbs_div
// Restoring divider, one quotient bit per cycle, for the Q1.16 ratio.
// ----------------------------------------------------------------------------
module swbs_div
    import swbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [CNT_W-1:0]      divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      den_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W:0]        rem_sh;
    logic                  ge;

    always_comb begin
        rem_sh    = {rem_reg, dq_reg[DIVIDEND_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        rem_next  = ge ? CNT_W'(rem_sh - {1'b0, den_reg}) : rem_sh[CNT_W-1:0];
        dq_next   = {dq_reg[DIVIDEND_W-2:0], ge};
        cnt_next  = cnt_reg - DIV_CNT_W'(1);
        busy_next = busy_reg;
        done_next = done_reg;
        if (busy_reg && (cnt_reg == DIV_CNT_W'(1))) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dq_reg;

endmodule

>>> sv/sliding_window_byte_stats.sv
// ----------------------------------------------------------------------------
// sliding_window_byte_stats
// Keeps the last window_size bytes of a stream and reports, every
// report_interval bytes once the window is full, a distinct or text count
// with its denominator and the Q1.16 ratio of the two.
//
// Input channel s_*: one byte per transaction. s_ready is high only while
// the sequencer is idle. Each byte passes through a ring read, a histogram
// read-modify-write for the evicted byte once the window is full, then one
// for the new byte. A byte that opens a report then loads the divider,
// which resolves one quotient bit per cycle over 27 bits to form the
// ratio, and the report moves to m_* once the divider is done and the
// output register is free.
// Result channel m_*: an output register holds the report; a new byte is
// taken while it waits. If the receiver stalls, the next report waits in
// the divider stage until the register frees up.
// Configuration by APB; writing window_size clears the window. Reset
// clears all counts and the histogram at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_byte_stats
    import swbs_pkg::*;
#(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_data_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [POS_W-1:0]   m_position,
    output logic [CNT_W-1:0]   m_stat_count,
    output logic [CNT_W-1:0]   m_denominator,
    output logic [RATIO_W-1:0] m_ratio_q16
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    function automatic logic is_text(input logic [BYTE_W-1:0] b);
        return (b == 8'h00) || ((b >= 8'h20) && (b <= 8'h7E));
    endfunction

    seq_state_t            state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [CNT_W-1:0]      window_size_reg, window_size_next;
    logic [PHASE_W-1:0]    report_interval_reg, report_interval_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [DIST_W-1:0]     distinct_all_reg, distinct_all_next;
    logic [DTXT_W-1:0]     distinct_text_reg, distinct_text_next;
    logic [CNT_W-1:0]      text_total_reg, text_total_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  evict_reg, evict_next;
    logic                  report_reg, report_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [CNT_W-1:0]      stat_reg, stat_next;
    logic [CNT_W-1:0]      den_reg, den_next;
    logic                  m_valid_reg, m_valid_next;
    logic [POS_W-1:0]      m_position_reg;
    logic [CNT_W-1:0]      m_stat_reg;
    logic [CNT_W-1:0]      m_den_reg;
    logic [RATIO_W-1:0]    m_ratio_reg;

    logic                  accept;
    logic                  cfg_wr;
    logic                  out_load;
    logic                  out_free;
    logic [CNT_W-1:0]      w_eff;
    logic [PHASE_W-1:0]    interval_eff;
    logic [XW-1:0]         head_inc;
    logic [PHASE_W:0]      phase_inc;
    logic [CNT_W-1:0]      stat_sel, den_sel;
    logic                  div_start;
    logic [BYTE_W-1:0]     ring_rdata;
    hist_cmd_t             hist_cmd;
    logic [CNT_W-1:0]      hist_rdata;
    div_status_t           div_status;
    logic [DIVIDEND_W-1:0] div_quotient;

    swbs_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .en    (accept),
        .addr  (head_reg),
        .wdata (s_data_byte),
        .rdata (ring_rdata)
    );

    swbs_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (hist_cmd),
        .rd_data (hist_rdata)
    );

    swbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({stat_sel, FRAC_W'(0)}),
        .divisor  (den_sel),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (window_size_reg == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(window_size_reg) > 32'(WINDOW_DEPTH)) begin
            w_eff = CNT_W'(WINDOW_DEPTH);
        end else begin
            w_eff = window_size_reg;
        end
        interval_eff = (report_interval_reg == '0) ? PHASE_W'(1) : report_interval_reg;
        head_inc     = XW'(head_reg) + XW'(1);
        phase_inc    = {1'b0, phase_reg} + (PHASE_W+1)'(1);
    end

    always_comb begin
        case (mode_reg)
            MODE_DISTINCT_TEXT: begin
                stat_sel = CNT_W'(distinct_text_reg);
                den_sel  = (w_eff < DEN_TEXT) ? w_eff : DEN_TEXT;
            end
            MODE_TEXT_TOTAL: begin
                stat_sel = text_total_reg;
                den_sel  = w_eff;
            end
            default: begin
                stat_sel = CNT_W'(distinct_all_reg);
                den_sel  = (w_eff < DEN_ALL) ? w_eff : DEN_ALL;
            end
        endcase
    end

    always_comb begin
        state_next           = state_reg;
        mode_next            = mode_reg;
        window_size_next     = window_size_reg;
        report_interval_next = report_interval_reg;
        head_next            = head_reg;
        fill_next            = fill_reg;
        distinct_all_next    = distinct_all_reg;
        distinct_text_next   = distinct_text_reg;
        text_total_next      = text_total_reg;
        position_next        = position_reg;
        phase_next           = phase_reg;
        evict_next           = evict_reg;
        report_next          = report_reg;
        byte_next            = byte_reg;
        stat_next            = stat_reg;
        den_next             = den_reg;
        div_start            = 1'b0;
        out_load             = 1'b0;
        hist_cmd             = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next     = s_data_byte;
                    evict_next    = (fill_reg >= w_eff);
                    head_next     = (head_inc >= XW'(w_eff)) ? '0 : AW'(head_inc);
                    fill_next     = (fill_reg < w_eff) ? fill_reg + CNT_W'(1) : fill_reg;
                    position_next = position_reg + POS_W'(1);
                    if (phase_inc >= {1'b0, interval_eff}) begin
                        phase_next  = '0;
                        report_next = (fill_next == w_eff);
                    end else begin
                        phase_next  = phase_inc[PHASE_W-1:0];
                        report_next = 1'b0;
                    end
                    state_next = ST_EVICT_RD;
                end
            end
            ST_EVICT_RD: begin
                if (evict_reg) begin
                    hist_cmd.rd_en   = 1'b1;
                    hist_cmd.rd_addr = ring_rdata;
                    state_next       = ST_EVICT_WR;
                end else begin
                    state_next = ST_ADD_RD;
                end
            end
            ST_EVICT_WR: begin
                if (hist_rdata != '0) begin
                    hist_cmd.wr_en   = 1'b1;
                    hist_cmd.wr_addr = ring_rdata;
                    hist_cmd.wr_data = hist_rdata - CNT_W'(1);
                    if (is_text(ring_rdata) && (text_total_reg != '0)) begin
                        text_total_next = text_total_reg - CNT_W'(1);
                    end
                    if (hist_rdata == CNT_W'(1)) begin
                        if (distinct_all_reg != '0) begin
                            distinct_all_next = distinct_all_reg - DIST_W'(1);
                        end
                        if (is_text(ring_rdata) && (distinct_text_reg != '0)) begin
                            distinct_text_next = distinct_text_reg - DTXT_W'(1);
                        end
                    end
                end
                state_next = ST_ADD_RD;
            end
            ST_ADD_RD: begin
                hist_cmd.rd_en   = 1'b1;
                hist_cmd.rd_addr = byte_reg;
                state_next       = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                hist_cmd.wr_en   = 1'b1;
                hist_cmd.wr_addr = byte_reg;
                hist_cmd.wr_data = hist_rdata + CNT_W'(1);
                if (hist_rdata == '0) begin
                    distinct_all_next = distinct_all_reg + DIST_W'(1);
                    if (is_text(byte_reg)) begin
                        distinct_text_next = distinct_text_reg + DTXT_W'(1);
                    end
                end
                if (is_text(byte_reg)) begin
                    text_total_next = text_total_reg + CNT_W'(1);
                end
                state_next = report_reg ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                div_start  = 1'b1;
                stat_next  = stat_sel;
                den_next   = den_sel;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_status.done && out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE: begin
                    mode_next = pwdata[MODE_W-1:0];
                end
                REG_WINDOW: begin
                    window_size_next   = pwdata[CNT_W-1:0];
                    head_next          = '0;
                    fill_next          = '0;
                    distinct_all_next  = '0;
                    distinct_text_next = '0;
                    text_total_next    = '0;
                    hist_cmd.clear     = 1'b1;
                end
                REG_INTERVAL: begin
                    report_interval_next = pwdata[PHASE_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:     prdata = PDATA_W'(mode_reg);
            REG_WINDOW:   prdata = PDATA_W'(window_size_reg);
            REG_INTERVAL: prdata = PDATA_W'(report_interval_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            mode_reg            <= MODE_DISTINCT_ALL;
            window_size_reg     <= WINDOW_RST;
            report_interval_reg <= INTERVAL_RST;
            head_reg            <= '0;
            fill_reg            <= '0;
            distinct_all_reg    <= '0;
            distinct_text_reg   <= '0;
            text_total_reg      <= '0;
            position_reg        <= '0;
            phase_reg           <= '0;
            evict_reg           <= 1'b0;
            report_reg          <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            mode_reg            <= mode_next;
            window_size_reg     <= window_size_next;
            report_interval_reg <= report_interval_next;
            head_reg            <= head_next;
            fill_reg            <= fill_next;
            distinct_all_reg    <= distinct_all_next;
            distinct_text_reg   <= distinct_text_next;
            text_total_reg      <= text_total_next;
            position_reg        <= position_next;
            phase_reg           <= phase_next;
            evict_reg           <= evict_next;
            report_reg          <= report_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        stat_reg <= stat_next;
        den_reg  <= den_next;
        if (out_load) begin
            m_position_reg <= position_reg;
            m_stat_reg     <= stat_reg;
            m_den_reg      <= den_reg;
            m_ratio_reg    <= div_quotient[RATIO_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_position    = m_position_reg;
    assign m_stat_count  = m_stat_reg;
    assign m_denominator = m_den_reg;
    assign m_ratio_q16   = m_ratio_reg;

`ifndef ASSERT_OFF
    a_fill_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= w_eff)
        else $error("fill level exceeds window");

    a_text_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(distinct_text_reg) <= CNT_W'(distinct_all_reg))
        else $error("distinct text count exceeds distinct count");

    a_text_total: assert property (@(posedge aclk) disable iff (!aresetn)
        text_total_reg <= fill_reg)
        else $error("text byte count exceeds fill level");

    a_report_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DIV) && $past(div_status.done))
        else $error("report raised outside divider completion");
`endif

endmodule

>>> bench/sliding_window_byte_stats_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_byte_stats_tb
// Self-checking bench for the sliding window byte statistics block. A short
// directed table walks the register extremes, every mode and the corner
// cases of window and interval; random phases reprogram the block and stream
// bytes with random gaps on both channels. Each report is compared field by
// field with its typed table row or an in-bench model of window and histogram.
// ----------------------------------------------------------------------------
module sliding_window_byte_stats_tb;
    import swbs_pkg::*;

    localparam int WINDOW_DEPTH   = 1024;
    localparam int RANDOM_BYTES   = 1600;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN      = 10;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   stat_count;
        logic [CNT_W-1:0]   denominator;
        logic [RATIO_W-1:0] ratio_q16;
    } stats_report_t;

    typedef enum logic {
        ROW_REG,
        ROW_BYTE
    } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [1:0]    reg_idx;
        logic [31:0]   value;
        bit            has_exp;
        stats_report_t exp_rep;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_data_byte = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [POS_W-1:0]   m_position;
    logic [CNT_W-1:0]   m_stat_count;
    logic [CNT_W-1:0]   m_denominator;
    logic [RATIO_W-1:0] m_ratio_q16;

    sliding_window_byte_stats #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_position    (m_position),
        .m_stat_count  (m_stat_count),
        .m_denominator (m_denominator),
        .m_ratio_q16   (m_ratio_q16)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // model of the window, histogram and registers
    logic [MODE_W-1:0]  cfg_mode = MODE_DISTINCT_ALL;
    logic [CNT_W-1:0]   cfg_window = WINDOW_RST;
    logic [PHASE_W-1:0] cfg_interval = INTERVAL_RST;
    logic [7:0]         win_bytes [WINDOW_DEPTH];
    int unsigned        byte_hist [HIST_DEPTH];
    int unsigned        win_head = 0;
    int unsigned        win_fill = 0;
    int unsigned        n_distinct = 0;
    int unsigned        n_text_distinct = 0;
    int unsigned        n_text = 0;
    logic [POS_W-1:0]   bytes_seen = '0;
    int unsigned        since_report = 0;

    stats_report_t expected_reports [$];
    stim_row_t     dir_rows [$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            sink_hold = 0;
    bit            src_idle = 1'b1;
    bit            sink_idle = 1'b1;
    bit            bytes_since_settle = 1'b0;

    function automatic bit is_text_byte(input logic [7:0] b);
        return (b == 8'h00) || (b >= 8'h20 && b <= 8'h7E);
    endfunction

    function automatic int unsigned active_window();
        if (cfg_window == 0)
            return 1;
        if (cfg_window > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return 32'(cfg_window);
    endfunction

    function automatic bit window_stats_step(input logic [7:0] b, output stats_report_t rep);
        int unsigned w;
        int unsigned iv;
        int unsigned stat;
        int unsigned den;
        logic [7:0]  old;
        logic [63:0] scaled;
        w = active_window();
        iv = (cfg_interval == 0) ? 1 : cfg_interval;
        rep = '0;
        if (win_fill >= w) begin
            old = win_bytes[win_head];
            if (byte_hist[old] != 0) begin
                byte_hist[old]--;
                if (is_text_byte(old) && n_text > 0)
                    n_text--;
                if (byte_hist[old] == 0) begin
                    if (n_distinct > 0)
                        n_distinct--;
                    if (is_text_byte(old) && n_text_distinct > 0)
                        n_text_distinct--;
                end
            end
        end
        win_bytes[win_head] = b;
        if (byte_hist[b] == 0) begin
            n_distinct++;
            if (is_text_byte(b))
                n_text_distinct++;
        end
        byte_hist[b]++;
        if (is_text_byte(b))
            n_text++;
        win_head = (win_head + 1 >= w) ? 0 : win_head + 1;
        if (win_fill < w)
            win_fill++;
        bytes_seen++;
        since_report++;
        if (since_report < iv)
            return 1'b0;
        since_report = 0;
        if (win_fill != w)
            return 1'b0;
        case (cfg_mode)
            MODE_DISTINCT_TEXT: begin
                stat = n_text_distinct;
                den = (w < DEN_TEXT) ? w : DEN_TEXT;
            end
            MODE_TEXT_TOTAL: begin
                stat = n_text;
                den = w;
            end
            default: begin
                stat = n_distinct;
                den = (w < DEN_ALL) ? w : DEN_ALL;
            end
        endcase
        scaled = (64'(stat) << FRAC_W) / den;
        rep.position = bytes_seen;
        rep.stat_count = stat[CNT_W-1:0];
        rep.denominator = den[CNT_W-1:0];
        rep.ratio_q16 = scaled[RATIO_W-1:0];
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input string what, input longint unsigned exp_val,
                                            input longint unsigned act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
    endfunction

    function automatic void check_report();
        stats_report_t exp_rep;
        if (expected_reports.size() == 0) begin
            report_mismatch("report with none pending, position", 0, m_position);
        end else begin
            exp_rep = expected_reports.pop_front();
            if (m_position !== exp_rep.position)
                report_mismatch("position", exp_rep.position, m_position);
            if (m_stat_count !== exp_rep.stat_count)
                report_mismatch("stat_count", exp_rep.stat_count, m_stat_count);
            if (m_denominator !== exp_rep.denominator)
                report_mismatch("denominator", exp_rep.denominator, m_denominator);
            if (m_ratio_q16 !== exp_rep.ratio_q16)
                report_mismatch("ratio_q16", exp_rep.ratio_q16, m_ratio_q16);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_report();
                sink_hold = sink_idle ? $urandom_range(0, 16) : 0;
            end
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                             input stats_report_t typed = '0);
        stats_report_t rep;
        int            gap;
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_since_settle = 1'b1;
        if (window_stats_step(b, rep) && !use_typed)
            expected_reports = {expected_reports, rep};
        if (use_typed)
            expected_reports = {expected_reports, typed};
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold off until every report is back and the block has gone quiet
    task automatic settle();
        if (bytes_since_settle) begin
            s_valid <= 1'b0;
            while (expected_reports.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            bytes_since_settle = 1'b0;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MODE: begin
                cfg_mode = val[MODE_W-1:0];
            end
            REG_WINDOW: begin
                cfg_window = val[CNT_W-1:0];
                foreach (byte_hist[i])
                    byte_hist[i] = 0;
                win_head = 0;
                win_fill = 0;
                n_distinct = 0;
                n_text_distinct = 0;
                n_text = 0;
            end
            REG_INTERVAL: begin
                cfg_interval = val[PHASE_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t row;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.value = val;
        row.has_exp = 1'b0;
        row.exp_rep = '0;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void add_byte(input logic [7:0] b, input bit has_exp = 1'b0,
                                     input logic [POS_W-1:0] pos = '0,
                                     input logic [CNT_W-1:0] stat = '0,
                                     input logic [CNT_W-1:0] den = '0,
                                     input logic [RATIO_W-1:0] ratio = '0);
        stim_row_t row;
        row.kind = ROW_BYTE;
        row.reg_idx = REG_MODE;
        row.value = {24'd0, b};
        row.has_exp = has_exp;
        row.exp_rep.position = pos;
        row.exp_rep.stat_count = stat;
        row.exp_rep.denominator = den;
        row.exp_rep.ratio_q16 = ratio;
        dir_rows = {dir_rows, row};
    endfunction

    initial begin
        int                 random_bytes;
        int                 phase_no;
        int                 n_bytes;
        int                 pick;
        bit                 set_win;
        logic [MODE_W-1:0]  new_mode;
        logic [CNT_W-1:0]   new_win;
        logic [PHASE_W-1:0] new_iv;
        logic [7:0]         alphabet [4];
        logic [7:0]         b;

        foreach (byte_hist[i])
            byte_hist[i] = 0;

        add_reg(REG_WINDOW, 1);
        add_reg(REG_INTERVAL, 1);
        add_reg(REG_MODE, 32'(MODE_DISTINCT_ALL));
        add_byte(8'h00, 1, 1, 1, 1, 65536);
        add_byte(8'hFF, 1, 2, 1, 1, 65536);
        add_reg(REG_MODE, 32'(MODE_DISTINCT_TEXT));
        add_byte(8'hFF, 1, 3, 0, 1, 0);
        add_byte(8'h7E, 1, 4, 1, 1, 65536);
        add_byte(8'h7F, 1, 5, 0, 1, 0);
        add_byte(8'h1F, 1, 6, 0, 1, 0);
        add_byte(8'h20, 1, 7, 1, 1, 65536);
        add_reg(REG_MODE, 32'(MODE_TEXT_TOTAL));
        add_byte(8'h00, 1, 8, 1, 1, 65536);
        add_byte(8'h80, 1, 9, 0, 1, 0);
        add_reg(REG_MODE, 32'(MODE_UNUSED));
        add_byte(8'hAA, 1, 10, 1, 1, 65536);
        add_reg(REG_WINDOW, 0);
        add_byte(8'h55, 1, 11, 1, 1, 65536);
        add_reg(REG_INTERVAL, 0);
        add_byte(8'h01, 1, 12, 1, 1, 65536);
        add_reg(REG_MODE, 32'(MODE_DISTINCT_ALL));
        add_reg(REG_WINDOW, 3);
        add_byte(8'h41);
        add_byte(8'h41);
        add_byte(8'h42, 1, 15, 2, 3, 43690);
        add_byte(8'h43, 1, 16, 3, 3, 65536);
        add_reg(REG_INTERVAL, 100);
        add_byte(8'h61);
        add_byte(8'h62);
        add_byte(8'h63);
        add_reg(REG_INTERVAL, 2);
        add_byte(8'h00);
        add_reg(REG_MODE, 32'(MODE_TEXT_TOTAL));
        add_byte(8'h7F);
        add_byte(8'h20);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                settle();
                apb_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_byte(dir_rows[i].value[7:0], dir_rows[i].has_exp, dir_rows[i].exp_rep);
            end
        end

        random_bytes = 0;
        phase_no = 0;
        while (random_bytes < RANDOM_BYTES) begin
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            new_mode = MODE_W'($urandom_range(0, 3));
            foreach (alphabet[i])
                alphabet[i] = 8'($urandom_range(0, 255));
            if (phase_no == 3) begin
                set_win = 1'b1;
                new_win = $urandom_range(0, 1) ? CNT_W'(WINDOW_DEPTH)
                                               : CNT_W'($urandom_range(WINDOW_DEPTH + 1, 2047));
                new_iv = PHASE_W'($urandom_range(1, 16));
            end else begin
                pick = $urandom_range(0, 9);
                set_win = (pick != 9);
                case (pick)
                    0: new_win = 0;
                    1: new_win = 1;
                    7, 8: new_win = CNT_W'($urandom_range(33, 200));
                    default: new_win = CNT_W'($urandom_range(2, 32));
                endcase
                pick = $urandom_range(0, 9);
                case (pick)
                    0: new_iv = 0;
                    1: new_iv = 24'hFFFFFF;
                    7, 8, 9: new_iv = PHASE_W'($urandom_range(5, 40));
                    default: new_iv = PHASE_W'($urandom_range(1, 4));
                endcase
            end
            settle();
            apb_write(REG_MODE, 32'(new_mode));
            if (set_win)
                apb_write(REG_WINDOW, 32'(new_win));
            apb_write(REG_INTERVAL, 32'(new_iv));
            n_bytes = active_window() + ((phase_no == 3) ? $urandom_range(100, 200)
                                                         : $urandom_range(10, 60));
            repeat (n_bytes) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: b = 8'($urandom_range(0, 255));
                    5, 6, 7: b = ($urandom_range(0, 20) == 0) ? 8'h00
                                                              : 8'($urandom_range(8'h20, 8'h7E));
                    default: b = alphabet[$urandom_range(0, 3)];
                endcase
                send_byte(b);
            end
            random_bytes += n_bytes;
            phase_no++;
        end

        settle();
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
